// ===== design/spq_pkg.sv =====
// Package for the sorted priority queue: sizes, codes and payload types.
`default_nettype none
package spq_pkg;

    localparam int DEPTH     = 16;
    localparam int ID_BITS   = 16;
    localparam int PRIO_BITS = 8;
    localparam int CNT_BITS  = $clog2(DEPTH + 1);

    typedef enum logic [1:0] {
        CMD_INSERT = 2'd0,
        CMD_POP_HI = 2'd1,
        CMD_POP_LO = 2'd2,
        CMD_REMOVE = 2'd3
    } spq_cmd_t;

    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_EMPTY    = 2'd1,
        ST_NOTFOUND = 2'd2,
        ST_FULL     = 2'd3
    } spq_status_t;

    typedef struct packed {
        spq_cmd_t               cmd;
        logic [ID_BITS-1:0]     id;
        logic [PRIO_BITS-1:0]   priority_req;
    } spq_req_t;

    typedef struct packed {
        spq_status_t            status;
        logic [ID_BITS-1:0]     out_id;
        logic [PRIO_BITS-1:0]   out_priority;
        logic [CNT_BITS-1:0]    count;
    } spq_rsp_t;

    typedef struct packed {
        logic [ID_BITS-1:0]     id;
        logic [PRIO_BITS-1:0]   prio;
    } spq_entry_t;

    // Operation broadcast to every cell; inserts are already qualified by full, pops by empty.
    typedef struct packed {
        logic ins;
        logic pop_hi;
        logic pop_lo;
        logic rem;
    } spq_op_t;

endpackage
`default_nettype wire

// ===== design/sorted_priority_queue.sv =====
// Top level of the sorted priority queue: request stage, cell chain, result register.
// A request accepted into the request register executes from there; its result is registered
// in the result register and held on m_data until it is taken.
// Throughput: one request per cycle while m_ready holds; the chain updates all slots at once.
// Backpressure: a request waits in the request register while the result is not taken.
// Reset: aresetn low empties the queue and clears both stage valids; slot data is not cleared.
`default_nettype none
module sorted_priority_queue import spq_pkg::*; (
    input  wire logic     aclk,
    input  wire logic     aresetn,
    input  wire logic     s_valid,
    output logic          s_ready,
    input  wire spq_req_t s_data,
    output logic          m_valid,
    input  wire logic     m_ready,
    output spq_rsp_t      m_data
);

    // Request stage
    logic       req_valid_reg, req_valid_next;
    spq_req_t   req_reg;

    // Result stage
    logic       rsp_valid_reg, rsp_valid_next;
    spq_rsp_t   rsp_reg, rsp_next;

    logic [CNT_BITS-1:0] count_reg, count_next;

    logic       exec;
    logic       full;
    logic       empty;
    spq_op_t    op;
    spq_entry_t new_entry;

    // Chain wiring, one element per cell
    spq_entry_t entry_q   [DEPTH];
    spq_entry_t sel_entry [DEPTH];
    logic [DEPTH-1:0] valid_q;
    logic [DEPTH-1:0] ge;
    logic [DEPTH-1:0] hit;

    spq_entry_t removed;

    // Execute when a request is held and the result register is free or draining.
    assign exec    = req_valid_reg && (!rsp_valid_reg || m_ready);
    assign s_ready = !req_valid_reg || exec;
    assign full    = (count_reg == CNT_BITS'(DEPTH));
    assign empty   = (count_reg == '0);

    assign new_entry.id   = req_reg.id;
    assign new_entry.prio = req_reg.priority_req;

    // Qualify the command: a refused insert or a pop from empty leaves the chain alone.
    always_comb begin
        op.ins    = exec && (req_reg.cmd == CMD_INSERT) && !full;
        op.pop_hi = exec && (req_reg.cmd == CMD_POP_HI) && !empty;
        op.pop_lo = exec && (req_reg.cmd == CMD_POP_LO) && !empty;
        op.rem    = exec && (req_reg.cmd == CMD_REMOVE);
    end

    // Cell chain: cell 0 sees a permanent valid, higher-ranked neighbor on its left.
    for (genvar i = 0; i < DEPTH; i++) begin : g_cell
        spq_entry_t le;
        spq_entry_t re;
        logic       lv;
        logic       lg;
        logic       hi;
        logic       rv;

        if (i == 0) begin : g_head
            assign le = new_entry;
            assign lv = 1'b1;
            assign lg = 1'b1;
            assign hi = 1'b0;
        end else begin : g_body
            assign le = entry_q[i-1];
            assign lv = valid_q[i-1];
            assign lg = ge[i-1];
            assign hi = hit[i-1];
        end

        if (i == DEPTH - 1) begin : g_tail
            assign re = '0;
            assign rv = 1'b0;
        end else begin : g_mid
            assign re = entry_q[i+1];
            assign rv = valid_q[i+1];
        end

        spq_cell u_cell (
            .aclk        (aclk),
            .aresetn     (aresetn),
            .op          (op),
            .new_entry   (new_entry),
            .left_entry  (le),
            .left_valid  (lv),
            .left_ge     (lg),
            .hit_in      (hi),
            .right_entry (re),
            .right_valid (rv),
            .entry_q     (entry_q[i]),
            .valid_q     (valid_q[i]),
            .ge          (ge[i]),
            .hit_out     (hit[i]),
            .sel_entry   (sel_entry[i])
        );
    end

    // Gather the removed entry: head for pop highest, else the one cell that selected itself.
    always_comb begin
        removed = '0;
        if (op.pop_hi) begin
            removed = entry_q[0];
        end else begin
            for (int k = 0; k < DEPTH; k++) begin
                removed = removed | sel_entry[k];
            end
        end
    end

    // Status and new count
    always_comb begin
        count_next            = count_reg;
        rsp_next              = rsp_reg;
        rsp_next.status       = ST_OK;
        rsp_next.out_id       = removed.id;
        rsp_next.out_priority = removed.prio;
        case (req_reg.cmd)
            CMD_INSERT: begin
                if (full) begin
                    rsp_next.status = ST_FULL;
                end else begin
                    count_next = count_reg + 1'b1;
                end
            end
            CMD_POP_HI, CMD_POP_LO: begin
                if (empty) begin
                    rsp_next.status = ST_EMPTY;
                end else begin
                    count_next = count_reg - 1'b1;
                end
            end
            CMD_REMOVE: begin
                if (empty) begin
                    rsp_next.status = ST_EMPTY;
                end else if (!hit[DEPTH-1]) begin
                    rsp_next.status = ST_NOTFOUND;
                end else begin
                    count_next = count_reg - 1'b1;
                end
            end
            default: begin
                count_next = count_reg;
            end
        endcase
        rsp_next.count = count_next;
    end

    // Stage valids: hold the request until executed, hold the result until taken.
    always_comb begin
        req_valid_next = req_valid_reg;
        if (exec) begin
            req_valid_next = 1'b0;
        end
        if (s_valid && s_ready) begin
            req_valid_next = 1'b1;
        end
        rsp_valid_next = rsp_valid_reg;
        if (m_ready) begin
            rsp_valid_next = 1'b0;
        end
        if (exec) begin
            rsp_valid_next = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            req_valid_reg <= 1'b0;
            rsp_valid_reg <= 1'b0;
            count_reg     <= '0;
        end else begin
            req_valid_reg <= req_valid_next;
            rsp_valid_reg <= rsp_valid_next;
            if (exec) begin
                count_reg <= count_next;
            end
        end
        if (s_valid && s_ready) begin
            req_reg <= s_data;
        end
        if (exec) begin
            rsp_reg <= rsp_next;
        end
    end

    assign m_valid = rsp_valid_reg;
    assign m_data  = rsp_reg;

endmodule
`default_nettype wire

// ===== design/spq_cell.sv =====
// One slot of the sorted chain: holds an entry and trades it with its neighbors.
`default_nettype none
module spq_cell import spq_pkg::*; (
    input  wire logic       aclk,
    input  wire logic       aresetn,
    input  wire spq_op_t    op,
    input  wire spq_entry_t new_entry,
    input  wire spq_entry_t left_entry,
    input  wire logic       left_valid,
    input  wire logic       left_ge,
    input  wire logic       hit_in,
    input  wire spq_entry_t right_entry,
    input  wire logic       right_valid,
    output spq_entry_t      entry_q,
    output logic            valid_q,
    output logic            ge,
    output logic            hit_out,
    output spq_entry_t      sel_entry
);

    spq_entry_t entry_reg, entry_next;
    logic       valid_reg, valid_next;
    logic       match;

    always_comb begin
        entry_next = entry_reg;
        valid_next = valid_reg;
        sel_entry  = '0;
        ge         = valid_reg && (entry_reg.prio >= new_entry.prio);
        match      = valid_reg && (entry_reg.id == new_entry.id);
        hit_out    = hit_in | match;

        if (op.ins) begin
            // Keep if we rank at or above the new entry, else take new or shift right.
            if (!ge) begin
                entry_next = left_ge ? new_entry : left_entry;
                valid_next = left_ge | left_valid;
            end
        end
        if (op.pop_hi) begin
            entry_next = right_entry;
            valid_next = right_valid;
        end
        if (op.pop_lo) begin
            valid_next = valid_reg & right_valid;
            if (valid_reg && !right_valid) begin
                sel_entry = entry_reg;
            end
        end
        if (op.rem) begin
            if (match && !hit_in) begin
                sel_entry = entry_reg;
            end
            if (hit_out) begin
                entry_next = right_entry;
                valid_next = right_valid;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
        entry_reg <= entry_next;
    end

    assign entry_q = entry_reg;
    assign valid_q = valid_reg;

endmodule
`default_nettype wire

// ===== design/spq_checker.sv =====
// Port checker for the sorted priority queue, bound to the top level.
`default_nettype none
module spq_checker import spq_pkg::*; (
    input wire logic     aclk,
    input wire logic     aresetn,
    input wire logic     s_ready,
    input wire logic     m_valid,
    input wire logic     m_ready,
    input wire spq_rsp_t m_data
);

    // A stalled result holds.
    a_rsp_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_data))
        else $error("result changed while stalled");

    // A failed command returns zero id and priority.
    a_zero_on_fail: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && (m_data.status != ST_OK) |-> (m_data.out_id == '0) &&
        (m_data.out_priority == '0))
        else $error("failed command returned an entry");

    // Count never exceeds the depth.
    a_count_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_data.count <= CNT_BITS'(DEPTH)))
        else $error("count beyond depth");

    // Empty and full status agree with the count.
    a_status_count: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> ((m_data.status != ST_EMPTY) || (m_data.count == '0)) &&
        ((m_data.status != ST_FULL) || (m_data.count == CNT_BITS'(DEPTH))))
        else $error("status disagrees with count");

    // With no result waiting, the input is always open.
    a_ready_when_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        !m_valid |-> s_ready)
        else $error("input blocked with no result waiting");

endmodule

bind sorted_priority_queue spq_checker u_spq_checker (
    .aclk    (aclk),
    .aresetn (aresetn),
    .s_ready (s_ready),
    .m_valid (m_valid),
    .m_ready (m_ready),
    .m_data  (m_data)
);
`default_nettype wire
